[src/sts_pkg.sv]
// Shared types, character codes and helpers for the S-expression token scanner.
// Used by sts_front, sts_queue, sts_back and sexpr_token_scanner_top.
package sts_pkg;

    // Token kinds as they appear on the result channel.
    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_NUMERIC = 3'd1;
    localparam logic [2:0] KIND_OPEN    = 3'd2;
    localparam logic [2:0] KIND_CLOSE   = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;
    localparam logic [2:0] KIND_EOF     = 3'd5;

    // Character codes.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_STOP    = 8'hFF;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;

    localparam logic [30:0] VALUE_MAX   = 31'h7FFF_FFFF;
    localparam logic [7:0]  LENGTH_MAX  = 8'hFF;
    localparam int          QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic [7:0]         token_length;
        logic [30:0]        numeric_value;
        logic [31:0]        literal_total;
        logic [31:0]        numeric_total;
        logic signed [31:0] numeric_sum;
        logic [31:0]        open_total;
        logic [31:0]        close_total;
        logic               last;
    } t_out_item;

    // One queue entry: the finished pending token (if any) and the token
    // that follows it in the same step (parenthesis or eof, if any).
    typedef struct packed {
        logic        has_flush;
        logic [2:0]  flush_kind;
        logic [7:0]  flush_length;
        logic [30:0] flush_value;
        logic        has_tail;
        logic [2:0]  tail_kind;
    } t_cmd;

    function automatic logic [31:0] sat_inc(input logic [31:0] x);
        sat_inc = (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
    endfunction

endpackage

[src/sts_front.sv]
// Front part of the token scanner: classifies bytes and tracks the pending token.
// Depends on sts_pkg; writes one command per token-producing byte to sts_queue.
module sts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  sts_pkg::t_in_item i_item,
    output logic              o_push,
    output sts_pkg::t_cmd     o_cmd
);

    logic [7:0]  r_len,       n_len;
    logic [30:0] r_value,     n_value;
    logic        r_could_lit, n_could_lit;
    logic        r_could_num, n_could_num;

    logic [7:0]  c;
    logic        eoi, is_sep, is_paren, is_digit, is_upper, pending;
    logic [7:0]  digit;
    logic [34:0] value_x10;

    always_comb begin
        c        = i_item.character;
        eoi      = i_item.end_of_input;
        is_sep   = (c == sts_pkg::CHAR_SPACE) || (c == sts_pkg::CHAR_CR) ||
                   (c == sts_pkg::CHAR_LF) || (c == sts_pkg::CHAR_STOP);
        is_paren = (c == sts_pkg::CHAR_LPAREN) || (c == sts_pkg::CHAR_RPAREN);
        is_digit = (c >= sts_pkg::CHAR_DIGIT_0) && (c <= sts_pkg::CHAR_DIGIT_9);
        is_upper = (c >= sts_pkg::CHAR_UPPER_A) && (c <= sts_pkg::CHAR_UPPER_Z);
        pending  = (r_len != 8'd0);
        digit    = c - sts_pkg::CHAR_DIGIT_0;
        value_x10 = ({4'b0, r_value} << 3) + ({4'b0, r_value} << 1) + {27'b0, digit};

        // Command for the back part.
        o_cmd.has_flush    = pending && (eoi || is_sep || is_paren);
        o_cmd.flush_length = r_len;
        if (r_could_lit) begin
            o_cmd.flush_kind  = sts_pkg::KIND_LITERAL;
            o_cmd.flush_value = '0;
        end else if (r_could_num) begin
            o_cmd.flush_kind  = sts_pkg::KIND_NUMERIC;
            o_cmd.flush_value = r_value;
        end else begin
            o_cmd.flush_kind  = sts_pkg::KIND_ERROR;
            o_cmd.flush_value = '0;
        end
        o_cmd.has_tail = eoi || (!is_sep && is_paren);
        if (eoi) begin
            o_cmd.tail_kind = sts_pkg::KIND_EOF;
        end else if (c == sts_pkg::CHAR_LPAREN) begin
            o_cmd.tail_kind = sts_pkg::KIND_OPEN;
        end else begin
            o_cmd.tail_kind = sts_pkg::KIND_CLOSE;
        end
        o_push = i_accept && (o_cmd.has_flush || o_cmd.has_tail);

        // Pending token update.
        n_len       = r_len;
        n_value     = r_value;
        n_could_lit = r_could_lit;
        n_could_num = r_could_num;
        if (i_accept) begin
            if (eoi || is_sep || is_paren) begin
                n_len       = '0;
                n_value     = '0;
                n_could_lit = 1'b0;
                n_could_num = 1'b0;
            end else begin
                if (!pending) begin
                    n_could_lit = is_upper;
                    n_could_num = is_digit;
                end else begin
                    n_could_lit = r_could_lit && (is_upper || is_digit);
                    n_could_num = r_could_num && is_digit;
                end
                if (is_digit) begin
                    n_value = (value_x10 > {4'b0, sts_pkg::VALUE_MAX}) ?
                              sts_pkg::VALUE_MAX : value_x10[30:0];
                end
                if (r_len != sts_pkg::LENGTH_MAX) begin
                    n_len = r_len + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_value     <= '0;
            r_could_lit <= 1'b0;
            r_could_num <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_value     <= n_value;
            r_could_lit <= n_could_lit;
            r_could_num <= n_could_num;
        end
    end

endmodule

[src/sts_queue.sv]
// Short command queue between the front and back parts of the token scanner.
// Depends on sts_pkg for the command type.
module sts_queue #(
    parameter int DEPTH = sts_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sts_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output sts_pkg::t_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sts_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    always_comb begin
        o_full  = (r_count == CW'(DEPTH));
        o_valid = (r_count != '0);
        o_cmd   = r_mem[r_rd_ptr];

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[src/sts_back.sv]
// Back part of the token scanner: emits tokens, keeps running totals.
// Depends on sts_pkg; reads commands from sts_queue, drives the result register.
module sts_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  sts_pkg::t_cmd      i_cmd,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sts_pkg::t_out_item o_result
);

    logic               r_phase, n_phase;
    logic               r_out_valid, n_out_valid;
    sts_pkg::t_out_item r_result, n_result;
    logic [31:0]        r_lit, n_lit;
    logic [31:0]        r_num, n_num;
    logic signed [31:0] r_sum, n_sum;
    logic [31:0]        r_open, n_open;
    logic [31:0]        r_close, n_close;

    logic        advance, on_flush, last;
    logic [2:0]  kind;
    logic [7:0]  len;
    logic [30:0] val;

    always_comb begin
        advance  = i_cmd_valid && (!r_out_valid || !i_out_stall);
        on_flush = i_cmd.has_flush && !r_phase;
        last     = !(on_flush && i_cmd.has_tail);
        o_pop    = advance && last;

        if (on_flush) begin
            kind = i_cmd.flush_kind;
            len  = i_cmd.flush_length;
            val  = i_cmd.flush_value;
        end else begin
            kind = i_cmd.tail_kind;
            len  = (i_cmd.tail_kind == sts_pkg::KIND_EOF) ? 8'd0 : 8'd1;
            val  = '0;
        end

        n_phase     = r_phase;
        n_out_valid = r_out_valid && i_out_stall;
        n_result    = r_result;
        n_lit       = r_lit;
        n_num       = r_num;
        n_sum       = r_sum;
        n_open      = r_open;
        n_close     = r_close;

        if (advance) begin
            n_phase     = !last;
            n_out_valid = 1'b1;
            // Totals on a result include its own token.
            unique case (kind)
                sts_pkg::KIND_LITERAL: n_lit   = sts_pkg::sat_inc(r_lit);
                sts_pkg::KIND_NUMERIC: begin
                    n_num = sts_pkg::sat_inc(r_num);
                    n_sum = r_sum + $signed({1'b0, val});
                end
                sts_pkg::KIND_OPEN:    n_open  = sts_pkg::sat_inc(r_open);
                sts_pkg::KIND_CLOSE:   n_close = sts_pkg::sat_inc(r_close);
                default: ;
            endcase
            n_result.token_kind    = kind;
            n_result.token_length  = len;
            n_result.numeric_value = val;
            n_result.literal_total = n_lit;
            n_result.numeric_total = n_num;
            n_result.numeric_sum   = n_sum;
            n_result.open_total    = n_open;
            n_result.close_total   = n_close;
            n_result.last          = last;
            // Eof carries the old totals, then clear them.
            if (kind == sts_pkg::KIND_EOF) begin
                n_lit   = '0;
                n_num   = '0;
                n_sum   = '0;
                n_open  = '0;
                n_close = '0;
            end
        end

        o_out_valid = r_out_valid;
        o_result    = r_result;
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_lit       <= '0;
            r_num       <= '0;
            r_sum       <= '0;
            r_open      <= '0;
            r_close     <= '0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_lit       <= n_lit;
            r_num       <= n_num;
            r_sum       <= n_sum;
            r_open      <= n_open;
            r_close     <= n_close;
        end
    end

endmodule

[src/sexpr_token_scanner_top.sv]
// Top level of the S-expression token scanner; instantiates sts_front, sts_queue, sts_back.
// Depends on sts_pkg for item types, token kinds and the queue depth default.
// Path: a byte's command is queued, then sts_back registers its first result.
// Throughput: one byte per cycle while the queue is not full; the single result port
//   emits one token per cycle unless stalled (queue absorbs a byte giving two tokens).
// Reset (synchronous, active low) clears the pending token, all totals, queue and output.
module sexpr_token_scanner_top #(
    parameter int QUEUE_DEPTH = sts_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Byte channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sts_pkg::t_in_item  i_in_item,
    // Token channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sts_pkg::t_out_item o_out_result
);

    logic          in_accept;
    logic          push;
    sts_pkg::t_cmd front_cmd;
    logic          queue_full;
    logic          queue_valid;
    sts_pkg::t_cmd queue_cmd;
    logic          pop;

    // Stall only when the queue has no room; the front never waits on results.
    assign o_in_stall = queue_full;
    assign in_accept  = i_in_valid && !queue_full;

    // Classify each byte and finish tokens.
    sts_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    // Decouple byte intake from result transfer.
    sts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd)
    );

    // Emit tokens one per transfer, updating the running totals.
    sts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_out_result)
    );

endmodule

[tb/sexpr_token_scanner_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sexpr_token_scanner_top: streams bytes, predicts tokens, compares.
// Depends on sts_pkg for the item types, token kinds and character codes.
module sexpr_token_scanner_top_tb;

    localparam int IDLE_LIMIT   = 1000;   // cycles with no transfer on either side
    localparam int RANDOM_BYTES = 570;    // bytes in the random phase, long token included
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_EVERY  = 120;

    // Token predictor and checker. Holds its own copy of the scanner state and the
    // tokens that are due on the result port, oldest first.
    class token_scoreboard;
        sts_pkg::t_out_item expected_tokens[$];
        logic [7:0]         pend_len;
        logic [30:0]        pend_val;
        logic               may_be_literal;
        logic               may_be_numeric;
        logic [31:0]        literal_count;
        logic [31:0]        numeric_count;
        logic signed [31:0] numeric_sum;
        logic [31:0]        open_count;
        logic [31:0]        close_count;
        int                 mismatches;
        int                 checked;
        int                 clipped_values;
        int                 clipped_lengths;
        int                 kind_seen[8];

        function new();
            clear_state();
        endfunction

        function void clear_pending();
            pend_len       = '0;
            pend_val       = '0;
            may_be_literal = 1'b0;
            may_be_numeric = 1'b0;
        endfunction

        function void clear_state();
            clear_pending();
            literal_count = '0;
            numeric_count = '0;
            numeric_sum   = '0;
            open_count    = '0;
            close_count   = '0;
        endfunction

        function logic [31:0] bump(logic [31:0] x);
            return (x == '1) ? x : x + 32'd1;
        endfunction

        // Queue a token carrying the totals as they stand right now.
        function void push_token(logic [2:0] kind, logic [7:0] len, logic [30:0] val);
            sts_pkg::t_out_item t;
            t.token_kind    = kind;
            t.token_length  = len;
            t.numeric_value = val;
            t.literal_total = literal_count;
            t.numeric_total = numeric_count;
            t.numeric_sum   = numeric_sum;
            t.open_total    = open_count;
            t.close_total   = close_count;
            t.last          = 1'b0;
            expected_tokens.push_back(t);
            kind_seen[kind]++;
        endfunction

        // Classify and emit the pending token, if there is one.
        function void close_pending();
            logic [2:0]  kind;
            logic [30:0] val;
            val = '0;
            if (pend_len == '0)
                return;
            if (may_be_literal) begin
                kind          = sts_pkg::KIND_LITERAL;
                literal_count = bump(literal_count);
            end else if (may_be_numeric) begin
                kind          = sts_pkg::KIND_NUMERIC;
                val           = pend_val;
                numeric_count = bump(numeric_count);
                numeric_sum   = numeric_sum + $signed({1'b0, val});
                if (val == sts_pkg::VALUE_MAX)
                    clipped_values++;
            end else begin
                kind = sts_pkg::KIND_ERROR;
            end
            if (pend_len == sts_pkg::LENGTH_MAX)
                clipped_lengths++;
            push_token(kind, pend_len, val);
            clear_pending();
        endfunction

        // Note one accepted byte and queue the tokens it gives.
        function void note_byte(sts_pkg::t_in_item b);
            int                 queued;
            logic [7:0]         c;
            logic               digit;
            logic               upper;
            logic [63:0]        grown;
            sts_pkg::t_out_item tail;
            c      = b.character;
            queued = expected_tokens.size();
            if (b.end_of_input) begin
                close_pending();
                push_token(sts_pkg::KIND_EOF, '0, '0);
                clear_state();
            end else if (c == sts_pkg::CHAR_SPACE || c == sts_pkg::CHAR_CR ||
                         c == sts_pkg::CHAR_LF || c == sts_pkg::CHAR_STOP) begin
                close_pending();
            end else if (c == sts_pkg::CHAR_LPAREN) begin
                close_pending();
                open_count = bump(open_count);
                push_token(sts_pkg::KIND_OPEN, 8'd1, '0);
            end else if (c == sts_pkg::CHAR_RPAREN) begin
                close_pending();
                close_count = bump(close_count);
                push_token(sts_pkg::KIND_CLOSE, 8'd1, '0);
            end else begin
                digit = (c >= sts_pkg::CHAR_DIGIT_0 && c <= sts_pkg::CHAR_DIGIT_9);
                upper = (c >= sts_pkg::CHAR_UPPER_A && c <= sts_pkg::CHAR_UPPER_Z);
                if (pend_len == '0) begin
                    may_be_literal = upper;
                    may_be_numeric = digit;
                end else begin
                    may_be_literal = may_be_literal && (upper || digit);
                    may_be_numeric = may_be_numeric && digit;
                end
                if (digit) begin
                    grown = {33'd0, pend_val} * 64'd10 +
                            {56'd0, c - sts_pkg::CHAR_DIGIT_0};
                    if (grown > {33'd0, sts_pkg::VALUE_MAX})
                        pend_val = sts_pkg::VALUE_MAX;
                    else
                        pend_val = grown[30:0];
                end
                if (pend_len != sts_pkg::LENGTH_MAX)
                    pend_len++;
            end
            if (expected_tokens.size() > queued) begin
                tail      = expected_tokens.pop_back();
                tail.last = 1'b1;
                expected_tokens.push_back(tail);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("token %0d, %s: expected %0h, got %0h", checked, field, want, got);
            end
        endfunction

        // Compare one transferred token with the oldest one due.
        function void check_token(sts_pkg::t_out_item got);
            sts_pkg::t_out_item want;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("token with none due: kind %0d, length %0d",
                             got.token_kind, got.token_length);
                return;
            end
            want = expected_tokens.pop_front();
            checked++;
            compare_field("kind", want.token_kind, got.token_kind);
            compare_field("length", want.token_length, got.token_length);
            compare_field("value", want.numeric_value, got.numeric_value);
            compare_field("literal total", want.literal_total, got.literal_total);
            compare_field("numeric total", want.numeric_total, got.numeric_total);
            compare_field("numeric sum", want.numeric_sum, got.numeric_sum);
            compare_field("open total", want.open_total, got.open_total);
            compare_field("close total", want.close_total, got.close_total);
            compare_field("last", want.last, got.last);
        endfunction

        function void finish_check();
            if (expected_tokens.size() != 0) begin
                mismatches += expected_tokens.size();
                if (mismatches <= MAX_REPORTS)
                    $display("%0d tokens due but never transferred", expected_tokens.size());
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    sts_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    sts_pkg::t_out_item o_out_result;

    token_scoreboard sb = new();
    int              bytes_sent;
    int              idle_cycles;
    logic            sender_quiet;

    sexpr_token_scanner_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_result (o_out_result)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Observe both channels at the rising edge: note each byte transfer, check each
    // token transfer, and end the run if neither side moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_byte(i_in_item);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_token(o_out_result);
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no transfer for %0d cycles, %0d tokens still due",
                     IDLE_LIMIT, sb.expected_tokens.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Token receiver: stall for a random number of cycles before each token, then hold
    // stall low until a token transfers. Quiet stretches take tokens back to back.
    initial begin
        int   hold;
        logic receiver_quiet;
        i_out_stall    = 1'b0;
        receiver_quiet = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 15) == 0)
                receiver_quiet = !receiver_quiet;
            hold = receiver_quiet ? 0 : $urandom_range(0, 5);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Drive one byte at a falling edge after a random gap; hold it until it transfers.
    // Valid stays high into the next byte when no gap is drawn.
    task automatic send_byte(input logic [7:0] c, input logic eoi);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item.character    = c;
        i_in_item.end_of_input = eoi;
        i_in_valid             = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    // Hold off the sender until every predicted token has been transferred.
    task automatic wait_for_tokens();
        i_in_valid = 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(negedge i_clk);
    endtask

    function automatic logic [7:0] rand_upper();
        return sts_pkg::CHAR_UPPER_A + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return sts_pkg::CHAR_DIGIT_0 + 8'($urandom_range(0, 9));
    endfunction

    // Letter or digit, as may follow the first letter of a literal.
    function automatic logic [7:0] rand_word_char();
        return $urandom_range(0, 1) ? rand_upper() : rand_digit();
    endfunction

    function automatic logic [7:0] rand_separator();
        case ($urandom_range(0, 3))
            0: return sts_pkg::CHAR_SPACE;
            1: return sts_pkg::CHAR_CR;
            2: return sts_pkg::CHAR_LF;
            default: return sts_pkg::CHAR_STOP;
        endcase
    endfunction

    // Any byte that neither separates nor is a parenthesis.
    function automatic logic [7:0] rand_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == sts_pkg::CHAR_SPACE || c == sts_pkg::CHAR_CR ||
               c == sts_pkg::CHAR_LF || c == sts_pkg::CHAR_STOP ||
               c == sts_pkg::CHAR_LPAREN || c == sts_pkg::CHAR_RPAREN);
        return c;
    endfunction

    initial begin
        int   random_start;
        int   next_drain;
        int   pick;
        int   len;
        logic long_number_done;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        sender_quiet = 1'b0;
        bytes_sent   = 0;
        idle_cycles  = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: open paren, literal spanning A, Z and 9, a zero number closed by a
        // paren (two tokens from one byte), a separator with nothing pending, a number
        // past the value limit, an unclassed token before a paren, an error token ended
        // by the stop byte, and a literal ended by end of input.
        send_text("(AZ9 0)");
        send_byte(sts_pkg::CHAR_CR, 1'b0);
        send_text("9999999999");
        send_byte(sts_pkg::CHAR_LF, 1'b0);
        send_text("a(1B");
        send_byte(sts_pkg::CHAR_STOP, 1'b0);
        send_text("Q");
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_for_tokens();

        // Random: mostly well-formed atoms and parens with separators between them,
        // plus error tokens, stray bytes, end of input, and one number past the
        // length limit closed by a paren.
        random_start     = bytes_sent;
        next_drain       = bytes_sent + DRAIN_EVERY;
        long_number_done = 1'b0;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if ($urandom_range(0, 9) == 0)
                sender_quiet = !sender_quiet;
            if (!long_number_done && bytes_sent - random_start > 250) begin
                len = $urandom_range(256, 262);
                repeat (len) send_byte(rand_digit(), 1'b0);
                send_byte(sts_pkg::CHAR_RPAREN, 1'b0);
                long_number_done = 1'b1;
            end

            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                send_byte(rand_upper(), 1'b0);
                len = $urandom_range(0, 7);
                repeat (len) send_byte(rand_word_char(), 1'b0);
            end else if (pick < 45) begin
                // Mostly short numbers; some long enough to clip the value.
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14)
                                                  : $urandom_range(1, 4);
                repeat (len) send_byte(rand_digit(), 1'b0);
            end else if (pick < 60) begin
                send_byte($urandom_range(0, 1) ? sts_pkg::CHAR_LPAREN
                                               : sts_pkg::CHAR_RPAREN, 1'b0);
            end else if (pick < 70) begin
                send_byte(rand_plain(), 1'b0);
                len = $urandom_range(0, 4);
                repeat (len)
                    send_byte($urandom_range(0, 1) ? rand_plain() : rand_word_char(), 1'b0);
            end else if (pick < 80) begin
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            end else if (pick < 83) begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            // Leave some atoms unseparated so neighbors run together.
            if ($urandom_range(0, 99) < 80)
                send_byte(rand_separator(), 1'b0);

            if (bytes_sent >= next_drain) begin
                wait_for_tokens();
                next_drain = bytes_sent + DRAIN_EVERY;
            end
        end

        // Flush whatever is pending, then let the pipeline empty.
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_for_tokens();
        repeat (8) @(posedge i_clk);
        sb.finish_check();

        $display("covered %0d bytes and %0d tokens: literal %0d, numeric %0d, error %0d,",
                 bytes_sent, sb.checked, sb.kind_seen[sts_pkg::KIND_LITERAL],
                 sb.kind_seen[sts_pkg::KIND_NUMERIC], sb.kind_seen[sts_pkg::KIND_ERROR]);
        $display("paren %0d, eof %0d; %0d numbers clipped, %0d tokens at the length limit",
                 sb.kind_seen[sts_pkg::KIND_OPEN] + sb.kind_seen[sts_pkg::KIND_CLOSE],
                 sb.kind_seen[sts_pkg::KIND_EOF], sb.clipped_values, sb.clipped_lengths);
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
src/sts_pkg.sv
src/sts_front.sv
src/sts_queue.sv
src/sts_back.sv
src/sexpr_token_scanner_top.sv
tb/sexpr_token_scanner_top_tb.sv
